[sv/fcafp_pkg.sv]
// Shared types and constants for the framed command arm/fire parser.
package fcafp_pkg;

  // Frame parser phases.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CODE_WAKEUP = 2'd0,
    REG_CODE_ARM    = 2'd1,
    REG_CODE_DISARM = 2'd2,
    REG_CODE_FIRE   = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  SYNC_BYTE   = 8'h41;
  localparam logic [3:0]  LEN_MASK    = 4'hf;
  localparam logic [10:0] PULSE_HIGH  = 11'd2000;
  localparam logic [10:0] PULSE_LOW   = 11'd1000;
  localparam logic [10:0] PULSE_OFF   = 11'd0;
  localparam logic [13:0] FLASH_SHORT = 14'd500;
  localparam logic [13:0] FLASH_LONG  = 14'd10000;
  localparam logic [1:0]  MASK_BLUE   = 2'b01;
  localparam logic [1:0]  MASK_AMBER  = 2'b10;

  // Command codes held in the configuration registers.
  typedef struct packed {
    logic [7:0] wakeup;
    logic [7:0] arm;
    logic [7:0] disarm;
    logic [7:0] fire;
  } codes_t;

  // Effect of one executed command.
  typedef struct packed {
    logic        servo_write;
    logic [10:0] servo_main;
    logic [10:0] servo_igniter;
    logic        led_request;
    logic [1:0]  led_mask;
    logic [13:0] led_time;
    logic        armed;
    logic        fired;
  } effect_t;

endpackage

[sv/fcafp_exec.sv]
// Command decoder: maps a stored command and the flags to servo, LED and flag effects.
module fcafp_exec (
  input  logic [7:0]        cmd_i,
  input  fcafp_pkg::codes_t codes_i,
  input  logic              armed_i,
  input  logic              fired_i,
  output fcafp_pkg::effect_t effect_o
);

  // First matching code wins, in the order wakeup, arm, disarm, fire.
  always_comb begin
    effect_o               = '0;
    effect_o.armed         = armed_i;
    effect_o.fired         = fired_i;
    if (cmd_i == codes_i.wakeup) begin
      effect_o.led_request = 1'b1;
      effect_o.led_mask    = fcafp_pkg::MASK_AMBER;
      effect_o.led_time    = fcafp_pkg::FLASH_SHORT;
    end else if (cmd_i == codes_i.arm) begin
      if (!fired_i) begin
        effect_o.servo_write   = 1'b1;
        effect_o.servo_main    = fcafp_pkg::PULSE_HIGH;
        effect_o.servo_igniter = fcafp_pkg::PULSE_LOW;
        effect_o.led_request   = 1'b1;
        effect_o.led_mask      = fcafp_pkg::MASK_BLUE | fcafp_pkg::MASK_AMBER;
        effect_o.led_time      = fcafp_pkg::FLASH_SHORT;
      end
      effect_o.armed = 1'b1;
    end else if (cmd_i == codes_i.disarm) begin
      if (!fired_i) begin
        effect_o.servo_write   = 1'b1;
        effect_o.servo_main    = fcafp_pkg::PULSE_OFF;
        effect_o.servo_igniter = fcafp_pkg::PULSE_OFF;
        effect_o.led_request   = 1'b1;
        effect_o.led_mask      = fcafp_pkg::MASK_BLUE;
        effect_o.led_time      = fcafp_pkg::FLASH_SHORT;
      end
      effect_o.armed = 1'b0;
    end else if (cmd_i == codes_i.fire) begin
      if (armed_i) begin
        effect_o.servo_write   = 1'b1;
        effect_o.servo_main    = fcafp_pkg::PULSE_LOW;
        effect_o.servo_igniter = fcafp_pkg::PULSE_HIGH;
        effect_o.led_request   = 1'b1;
        effect_o.led_mask      = fcafp_pkg::MASK_BLUE;
        effect_o.led_time      = fcafp_pkg::FLASH_LONG;
        effect_o.fired         = 1'b1;
        effect_o.armed         = 1'b0;
      end
    end
  end

endmodule

[sv/framed_command_arm_fire_parser.sv]
// Top level of the framed command parser with arm/fire servo control.
// The result for a byte is registered and appears on the output in the cycle after the byte is accepted.
// One byte per cycle unless out_ready_i stalls; the sole output register refills as it drains.
// The per-byte parse and command decode is one shallow combinational pass into that register.
// Reset clears the parser phase, counters, flags and output valid, and loads the default codes.
module framed_command_arm_fire_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        servo_write_o,
  output logic [10:0] servo_main_o,
  output logic [10:0] servo_igniter_o,
  output logic        led_request_o,
  output logic [1:0]  led_mask_o,
  output logic [13:0] led_time_o,
  output logic        frame_accepted_o,
  output logic        armed_now_o,
  output logic        fired_now_o
);

  fcafp_pkg::codes_t  codes_q;
  fcafp_pkg::phase_e  phase_q, phase_d;
  logic [3:0]         len_q, len_d;
  logic [3:0]         seen_q, seen_d;
  logic [7:0]         cmd_q, cmd_d;
  logic               armed_q, armed_d;
  logic               fired_q, fired_d;
  logic               accept;

  fcafp_pkg::effect_t exec_eff;
  fcafp_pkg::effect_t res_d, res_q;
  logic               acc_d, acc_q;
  logic               out_valid_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.wakeup <= 8'd0;
      codes_q.arm    <= 8'd1;
      codes_q.disarm <= 8'd2;
      codes_q.fire   <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcafp_pkg::REG_CODE_WAKEUP: codes_q.wakeup <= cfg_wdata_i;
        fcafp_pkg::REG_CODE_ARM:    codes_q.arm    <= cfg_wdata_i;
        fcafp_pkg::REG_CODE_DISARM: codes_q.disarm <= cfg_wdata_i;
        fcafp_pkg::REG_CODE_FIRE:   codes_q.fire   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Command decode from the stored command byte.
  fcafp_exec u_exec (
    .cmd_i    (cmd_q),
    .codes_i  (codes_q),
    .armed_i  (armed_q),
    .fired_i  (fired_q),
    .effect_o (exec_eff)
  );

  // Next parser state and the result for the current byte.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    cmd_d   = cmd_q;
    armed_d = armed_q;
    fired_d = fired_q;
    acc_d   = 1'b0;
    res_d   = '0;
    case (phase_q)
      fcafp_pkg::PH_IDLE: begin
        if (rx_byte_i == fcafp_pkg::SYNC_BYTE) begin
          phase_d = fcafp_pkg::PH_LENGTH;
        end
      end
      fcafp_pkg::PH_LENGTH: begin
        len_d   = rx_byte_i[3:0] & fcafp_pkg::LEN_MASK;
        seen_d  = 4'd0;
        phase_d = (len_d == 4'd0) ? fcafp_pkg::PH_CHECK : fcafp_pkg::PH_DATA;
      end
      fcafp_pkg::PH_DATA: begin
        if (seen_q == 4'd0) begin
          cmd_d = rx_byte_i;
        end
        seen_d = seen_q + 4'd1;
        if (seen_d == len_q) begin
          phase_d = fcafp_pkg::PH_CHECK;
        end
      end
      fcafp_pkg::PH_CHECK: begin
        phase_d = fcafp_pkg::PH_IDLE;
        if (rx_byte_i == 8'd0) begin
          acc_d = 1'b1;
          if (seen_q != 4'd0) begin
            res_d   = exec_eff;
            armed_d = exec_eff.armed;
            fired_d = exec_eff.fired;
          end
        end
      end
      default: phase_d = fcafp_pkg::PH_IDLE;
    endcase
    res_d.armed = armed_d;
    res_d.fired = fired_d;
  end

  // Parser state, advanced on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fcafp_pkg::PH_IDLE;
      len_q   <= 4'd0;
      seen_q  <= 4'd0;
      armed_q <= 1'b0;
      fired_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      armed_q <= armed_d;
      fired_q <= fired_d;
    end
  end

  // Command byte holds only payload and needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      acc_q <= acc_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign servo_write_o    = res_q.servo_write;
  assign servo_main_o     = res_q.servo_main;
  assign servo_igniter_o  = res_q.servo_igniter;
  assign led_request_o    = res_q.led_request;
  assign led_mask_o       = res_q.led_mask;
  assign led_time_o       = res_q.led_time;
  assign frame_accepted_o = acc_q;
  assign armed_now_o      = res_q.armed;
  assign fired_now_o      = res_q.fired;

endmodule
